@@ src/dba_pkg.sv @@
// Package for the disk block allocator: state encoding, status and mode codes,
// and the default disk size. Used by the top level and its checker.
`default_nettype none
package dba_pkg;

  localparam int NUM_BLOCKS_DEF = 64;
  localparam int MAX_RESULTS = 64;

  localparam logic [1:0] MODE_CONTIG  = 2'd0;
  localparam logic [1:0] MODE_INDEXED = 2'd1;
  localparam logic [1:0] MODE_LINKED  = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOSPACE    = 2'd1;
  localparam logic [1:0] ST_INDEX_BUSY = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FAIL,
    S_CONT,
    S_IDX,
    S_GRD,
    S_GCHK
  } dba_state_t;

endpackage
`default_nettype wire

@@ src/dba_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
`default_nettype none
module dba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/disk_block_allocator_top.sv @@
// Top level of the disk block allocator: sequencer, request registers and
// output register around one bitmap RAM. Depends on dba_pkg and dba_ram.
//
// After reset the block clears its bitmap, with in_ready low. A request then
// scans the whole bitmap through its single read port, followed by the grants:
// in contiguous mode the blocks of the first long enough free run, in order, and
// in linked or indexed mode a read, then a check, of every bitmap entry visited
// up to the last block granted, with the index block granted first. A rejected
// request (bad mode or size) skips the scan: its status passes through the fail
// state and the output register. Results leave through an output register and
// stall the sequencer only while that register is full and not taken.
`default_nettype none
module disk_block_allocator_top
  import dba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_mode,
  input  wire logic [6:0] in_file_size,
  input  wire logic [5:0] in_index_block,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [5:0] out_block_number,
  output logic            out_is_index,
  output logic      [1:0] out_status,
  output logic            out_last
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int IW = (AW > 6) ? AW : 6;
  localparam int SW = (CW > 7) ? CW : 7;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);

  dba_state_t state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] proc_idx_r, proc_idx_nxt;
  logic          proc_vld_r, proc_vld_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [6:0]    size_r, size_nxt;
  logic [5:0]    ib_r, ib_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic          found_r, found_nxt;
  logic          ib_used_r, ib_used_nxt;
  logic [6:0]    remain_r, remain_nxt;
  logic [1:0]    fail_st_r, fail_st_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [5:0]    out_blk_r, out_blk_nxt;
  logic          out_idx_r, out_idx_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic          out_last_r, out_last_nxt;

  logic          ram_wr_en, ram_rd_en, ram_wr_data, ram_rd_data;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;

  logic          slot_free, bad_req, is_skip_proc, is_skip_chk;
  logic [IW-1:0] ib_ext, addr_ext;
  logic [AW-1:0] ib_addr;

  dba_ram #(
    .WIDTH(1),
    .DEPTH(NUM_BLOCKS)
  ) u_map (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign slot_free    = !out_valid_r || out_ready;
  assign ib_ext       = IW'(ib_r);
  assign ib_addr      = ib_ext[AW-1:0];
  assign addr_ext     = IW'(addr_r);
  assign is_skip_proc = (mode_r == MODE_INDEXED) && (IW'(proc_idx_r) == ib_ext);
  assign is_skip_chk  = (mode_r == MODE_INDEXED) && (addr_ext == ib_ext);
  assign bad_req      = ((in_mode != MODE_CONTIG) && (in_mode != MODE_INDEXED) &&
                         (in_mode != MODE_LINKED)) || (in_file_size == 7'd0) ||
                        (in_file_size > 7'(MAX_RESULTS)) ||
                        ((in_mode == MODE_INDEXED) && (in_file_size > 7'(MAX_RESULTS - 1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      proc_vld_r  <= proc_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
    mode_r     <= mode_nxt;
    size_r     <= size_nxt;
    ib_r       <= ib_nxt;
    cnt_r      <= cnt_nxt;
    run_r      <= run_nxt;
    start_r    <= start_nxt;
    found_r    <= found_nxt;
    ib_used_r  <= ib_used_nxt;
    remain_r   <= remain_nxt;
    fail_st_r  <= fail_st_nxt;
    out_blk_r  <= out_blk_nxt;
    out_idx_r  <= out_idx_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    proc_idx_nxt  = proc_idx_r;
    proc_vld_nxt  = 1'b0;
    mode_nxt      = mode_r;
    size_nxt      = size_r;
    ib_nxt        = ib_r;
    cnt_nxt       = cnt_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    found_nxt     = found_r;
    ib_used_nxt   = ib_used_r;
    remain_nxt    = remain_r;
    fail_st_nxt   = fail_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_blk_nxt   = out_blk_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = addr_r;
    ram_wr_data   = 1'b1;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = addr_r;
    in_ready      = 1'b0;

    if (proc_vld_r) begin
      if (!ram_rd_data && !is_skip_proc) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (is_skip_proc) begin
        ib_used_nxt = ram_rd_data;
      end
      if (!found_r) begin
        if (!ram_rd_data) begin
          if (run_r == '0) begin
            start_nxt = proc_idx_r;
          end
          run_nxt = run_r + 1'b1;
          if (SW'(run_r) + SW'(1) == SW'(size_r)) begin
            found_nxt = 1'b1;
          end
        end else begin
          run_nxt = '0;
        end
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = 1'b0;
        addr_nxt    = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt    = in_mode;
          size_nxt    = in_file_size;
          ib_nxt      = in_index_block;
          cnt_nxt     = '0;
          run_nxt     = '0;
          found_nxt   = 1'b0;
          ib_used_nxt = 1'b1;
          addr_nxt    = '0;
          if (bad_req) begin
            fail_st_nxt = ST_NOSPACE;
            state_nxt   = S_FAIL;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_rd_en    = 1'b1;
        proc_vld_nxt = 1'b1;
        proc_idx_nxt = addr_r;
        addr_nxt     = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        remain_nxt  = size_r;
        fail_st_nxt = ST_NOSPACE;
        if (mode_r == MODE_CONTIG) begin
          addr_nxt  = start_r;
          state_nxt = found_r ? S_CONT : S_FAIL;
        end else if (mode_r == MODE_INDEXED && ib_used_r) begin
          fail_st_nxt = ST_INDEX_BUSY;
          state_nxt   = S_FAIL;
        end else if (SW'(cnt_r) < SW'(size_r)) begin
          state_nxt = S_FAIL;
        end else begin
          addr_nxt  = '0;
          state_nxt = (mode_r == MODE_INDEXED) ? S_IDX : S_GRD;
        end
      end
      S_FAIL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = 6'd0;
          out_idx_nxt   = 1'b0;
          out_st_nxt    = fail_st_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CONT: begin
        if (slot_free) begin
          ram_wr_en     = 1'b1;
          out_valid_nxt = 1'b1;
          out_blk_nxt   = addr_ext[5:0];
          out_idx_nxt   = 1'b0;
          out_st_nxt    = ST_OK;
          out_last_nxt  = (remain_r == 7'd1);
          addr_nxt      = addr_r + 1'b1;
          remain_nxt    = remain_r - 7'd1;
          if (remain_r == 7'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDX: begin
        if (slot_free) begin
          ram_wr_en     = 1'b1;
          ram_wr_addr   = ib_addr;
          out_valid_nxt = 1'b1;
          out_blk_nxt   = ib_r;
          out_idx_nxt   = 1'b1;
          out_st_nxt    = ST_OK;
          out_last_nxt  = 1'b0;
          state_nxt     = S_GRD;
        end
      end
      S_GRD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_GCHK;
      end
      S_GCHK: begin
        if (!ram_rd_data && !is_skip_chk) begin
          if (slot_free) begin
            ram_wr_en     = 1'b1;
            out_valid_nxt = 1'b1;
            out_blk_nxt   = addr_ext[5:0];
            out_idx_nxt   = 1'b0;
            out_st_nxt    = ST_OK;
            out_last_nxt  = (remain_r == 7'd1);
            remain_nxt    = remain_r - 7'd1;
            addr_nxt      = addr_r + 1'b1;
            state_nxt     = (remain_r == 7'd1) ? S_IDLE : S_GRD;
          end
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_GRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_block_number = out_blk_r;
  assign out_is_index     = out_idx_r;
  assign out_status       = out_st_r;
  assign out_last         = out_last_r;

endmodule
`default_nettype wire

@@ src/dba_checker.sv @@
// Port-level checker for the disk block allocator, with its bind statement.
// Depends on dba_pkg and on the port list of disk_block_allocator_top.
`default_nettype none
module dba_checker
  import dba_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] out_block_number,
  input wire logic       out_is_index,
  input wire logic [1:0] out_status,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_block_number) &&
    $stable(out_status) && $stable(out_last) && $stable(out_is_index))
    else $error("Stalled result item changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Block took a new item while busy.");

  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_block_number == 6'd0)
    else $error("Failure item is not a single zero-block item.");

  a_index_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_index |-> out_status == ST_OK && !out_last)
    else $error("Index block item is malformed.");

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("Block ready in the middle of a request.");

endmodule

bind disk_block_allocator_top dba_checker u_dba_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_block_number(out_block_number),
  .out_is_index    (out_is_index),
  .out_status      (out_status),
  .out_last        (out_last)
);
`default_nettype wire
